// File: rtl/dap_pkg.sv
package dap_pkg;

  // field widths
  localparam int POS_W   = 32;
  localparam int SCALE_W = 16;
  localparam int GAIN_W  = 16;
  localparam int M_W     = 40;   // far * far scale / 2^8
  localparam int ZS_W    = 40;   // scaled z magnitude
  localparam int ZSQ_W   = 80;
  localparam int H_W     = 32;   // horizontal distance
  localparam int D_W     = 41;   // 3-d distance
  localparam int SIDE_W  = 33;   // h +/- x, clamped to 2h
  localparam int QUO_W   = 29;   // divider quotient bits
  localparam int GDEN_W  = 40;
  localparam int G_W     = 15;   // distance gain, Q1.14
  localparam int FAC_W   = 15;   // pan factor, Q1.14

  localparam logic [SCALE_W-1:0] FAR_SCALE_RESET = 16'd256;
  localparam logic [G_W-1:0]     GAIN_ONE        = 15'd16384;
  localparam logic [QUO_W-1:0]   PAN_CENTER      = 29'd134217728;

  // distance gain source
  typedef enum logic [1:0] {
    GSEL_ONE,
    GSEL_ZERO,
    GSEL_DIV
  } gsel_t;

  // per-voice context through the front stages
  typedef struct packed {
    logic               spatial;
    logic [GAIN_W-1:0]  base;
    logic [POS_W-1:0]   near;
    logic [M_W-1:0]     m;
    logic [POS_W-1:0]   xm;
    logic               xneg;
  } vctx_t;

  typedef struct packed {
    vctx_t              ctx;
    logic [POS_W-1:0]   ym;
    logic [POS_W-1:0]   zm;
    logic [SCALE_W-1:0] hs;
  } s1_t;

  typedef struct packed {
    vctx_t              ctx;
    logic [63:0]        xx;
    logic [63:0]        yy;
    logic [ZS_W-1:0]    zs;
  } s2_t;

  typedef struct packed {
    vctx_t              ctx;
    logic [63:0]        xx;
    logic [63:0]        yy;
    logic [15:0]        zhh;
    logic [39:0]        zhl;
    logic [63:0]        zll;
  } s3_t;

  // carried alongside the horizontal root
  typedef struct packed {
    vctx_t              ctx;
    logic [ZSQ_W-1:0]   zsq;
  } htag_t;

  typedef struct packed {
    htag_t              tag;
    logic [H_W-1:0]     h;
    logic [63:0]        hh;
  } s5_t;

  // carried alongside the 3-d root
  typedef struct packed {
    logic               spatial;
    logic [GAIN_W-1:0]  base;
    logic [POS_W-1:0]   near;
    logic [M_W-1:0]     m;
    logic [H_W-1:0]     h;
    logic [SIDE_W-1:0]  lo;
    logic [SIDE_W-1:0]  hi;
  } dtag_t;

  typedef struct packed {
    logic                      spatial;
    logic [GAIN_W-1:0]         base;
    gsel_t                     gsel;
    logic                      hzero;
    logic [QUO_W+GDEN_W-1:0]   gnum;
    logic [GDEN_W-1:0]         gden;
    logic [QUO_W+H_W-1:0]      lnum;
    logic [QUO_W+H_W-1:0]      rnum;
    logic [H_W-1:0]            pden;
  } s6_t;

  // carried alongside the dividers
  typedef struct packed {
    logic               spatial;
    logic [GAIN_W-1:0]  base;
    gsel_t              gsel;
    logic               hzero;
  } qtag_t;

  // carried alongside the pan roots
  typedef struct packed {
    logic               spatial;
    logic [GAIN_W-1:0]  base;
    logic [G_W-1:0]     g;
  } ftag_t;

  typedef struct packed {
    logic               spatial;
    logic [GAIN_W-1:0]  base;
    logic [30:0]        bg;
    logic [FAC_W-1:0]   lf;
    logic [FAC_W-1:0]   rf;
  } s7_t;

endpackage

// File: rtl/distance_attenuation_panner_unit.sv
// channel  | beat signals            | payload
// ---------+-------------------------+------------------------------------------
// cfg      | cfg_valid / cfg_ready   | cfg_data (far scale, Q8.8)
// in       | in_valid / in_ready     | spatial_enable, pos_x/y/z, height_scale,
//          |                         | near_distance, far_distance, base_gain
// out      | out_valid / out_ready   | left_gain, right_gain
//
// one voice accepted per cycle unless the pipeline holds; the path runs through the
// bit-per-stage roots (32 + 41 + 15 stages) and the 29-stage dividers
// rst clears all stage valid bits and loads the far scale with 1.0
// the whole pipeline holds while the output register is full and not taken
module distance_attenuation_panner_unit import dap_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [SCALE_W-1:0]        cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      spatial_enable,
  input  logic signed [POS_W-1:0]   pos_x,
  input  logic signed [POS_W-1:0]   pos_y,
  input  logic signed [POS_W-1:0]   pos_z,
  input  logic [SCALE_W-1:0]        height_scale,
  input  logic [POS_W-1:0]          near_distance,
  input  logic [POS_W-1:0]          far_distance,
  input  logic [GAIN_W-1:0]         base_gain,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [GAIN_W-1:0]         left_gain,
  output logic [GAIN_W-1:0]         right_gain
);

  logic [SCALE_W-1:0] far_scale;
  logic               adv;

  logic s1_vld, s2_vld, s3_vld, s5_vld, s6_vld, s7_vld;
  s1_t  s1;
  s2_t  s2;
  s3_t  s3;
  s5_t  s5;
  s6_t  s6;
  s7_t  s7;

  // config register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      far_scale <= FAR_SCALE_RESET;
    end else if (cfg_valid) begin
      far_scale <= cfg_data;
    end
  end

  // global advance
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // stage 1: magnitudes and scaled far distance
  logic [POS_W-1:0] ux, uy, uz;
  logic [47:0]      far_prod;

  always_comb begin
    ux       = pos_x;
    uy       = pos_y;
    uz       = pos_z;
    far_prod = far_distance * far_scale;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1.ctx.spatial <= spatial_enable;
      s1.ctx.base    <= base_gain;
      s1.ctx.near    <= near_distance;
      s1.ctx.m       <= far_prod[47:8];
      s1.ctx.xm      <= ux[POS_W-1] ? (~ux + 32'd1) : ux;
      s1.ctx.xneg    <= ux[POS_W-1];
      s1.ym          <= uy[POS_W-1] ? (~uy + 32'd1) : uy;
      s1.zm          <= uz[POS_W-1] ? (~uz + 32'd1) : uz;
      s1.hs          <= height_scale;
    end
  end

  // stage 2: squares and vertical scale
  logic [63:0] xx_c, yy_c;
  logic [47:0] z_prod;

  always_comb begin
    xx_c   = s1.ctx.xm * s1.ctx.xm;
    yy_c   = s1.ym * s1.ym;
    z_prod = s1.zm * s1.hs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (adv) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2.ctx <= s1.ctx;
      s2.xx  <= xx_c;
      s2.yy  <= yy_c;
      s2.zs  <= z_prod[47:8];
    end
  end

  // stage 3: partial products of zs squared
  logic [15:0] zhh_c;
  logic [39:0] zhl_c;
  logic [63:0] zll_c;

  always_comb begin
    zhh_c = s2.zs[39:32] * s2.zs[39:32];
    zhl_c = s2.zs[39:32] * s2.zs[31:0];
    zll_c = s2.zs[31:0] * s2.zs[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (adv) begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3.ctx <= s2.ctx;
      s3.xx  <= s2.xx;
      s3.yy  <= s2.yy;
      s3.zhh <= zhh_c;
      s3.zhl <= zhl_c;
      s3.zll <= zll_c;
    end
  end

  // horizontal root
  htag_t       h_in_tag, h_out_tag;
  logic [63:0] hsq;
  logic        h_vld;
  logic [H_W-1:0] h_root;

  always_comb begin
    hsq          = s3.xx + s3.yy;
    h_in_tag.ctx = s3.ctx;
    h_in_tag.zsq = {s3.zhh, 64'b0} + {7'b0, s3.zhl, 33'b0} + {16'b0, s3.zll};
  end

  dap_sqrt_pipe #(
    .RW    (H_W),
    .TAG_W ($bits(htag_t))
  ) u_h_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s3_vld),
    .in_rad    (hsq),
    .in_tag    (h_in_tag),
    .out_valid (h_vld),
    .out_root  (h_root),
    .out_tag   (h_out_tag)
  );

  // stage 5: h squared
  logic [63:0] hh_c;

  assign hh_c = h_root * h_root;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else if (adv) begin
      s5_vld <= h_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5.tag <= h_out_tag;
      s5.h   <= h_root;
      s5.hh  <= hh_c;
    end
  end

  // 3-d root, pan sides formed alongside
  dtag_t            d_in_tag, d_out_tag;
  logic [2*D_W-1:0] dsq;
  logic [SIDE_W-1:0] hsum, hdif, h2, lo_raw, hi_raw;
  logic             d_vld;
  logic [D_W-1:0]   d_root;

  always_comb begin
    dsq    = {2'b0, s5.tag.zsq} + {18'b0, s5.hh};
    hsum   = {1'b0, s5.h} + {1'b0, s5.tag.ctx.xm};
    hdif   = (s5.h > s5.tag.ctx.xm) ? {1'b0, s5.h - s5.tag.ctx.xm} : '0;
    h2     = {s5.h, 1'b0};
    lo_raw = s5.tag.ctx.xneg ? hsum : hdif;
    hi_raw = s5.tag.ctx.xneg ? hdif : hsum;
    d_in_tag.spatial = s5.tag.ctx.spatial;
    d_in_tag.base    = s5.tag.ctx.base;
    d_in_tag.near    = s5.tag.ctx.near;
    d_in_tag.m       = s5.tag.ctx.m;
    d_in_tag.h       = s5.h;
    d_in_tag.lo      = (lo_raw > h2) ? h2 : lo_raw;
    d_in_tag.hi      = (hi_raw > h2) ? h2 : hi_raw;
  end

  dap_sqrt_pipe #(
    .RW    (D_W),
    .TAG_W ($bits(dtag_t))
  ) u_d_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s5_vld),
    .in_rad    (dsq),
    .in_tag    (d_in_tag),
    .out_valid (d_vld),
    .out_root  (d_root),
    .out_tag   (d_out_tag)
  );

  // stage 6: gain region and divider operands
  gsel_t        gsel_c;
  logic [M_W-1:0] mdiff;

  always_comb begin
    if (d_root <= {9'b0, d_out_tag.near}) begin
      gsel_c = GSEL_ONE;
    end else if (d_root >= {1'b0, d_out_tag.m}) begin
      gsel_c = GSEL_ZERO;
    end else begin
      gsel_c = GSEL_DIV;
    end
    mdiff = d_out_tag.m - d_root[M_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
    end else if (adv) begin
      s6_vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6.spatial <= d_out_tag.spatial;
      s6.base    <= d_out_tag.base;
      s6.gsel    <= gsel_c;
      s6.hzero   <= (d_out_tag.h == '0);
      s6.gnum    <= {15'b0, mdiff, 14'b0};
      s6.gden    <= d_out_tag.m - {8'b0, d_out_tag.near};
      s6.lnum    <= {1'b0, d_out_tag.lo, 27'b0};
      s6.rnum    <= {1'b0, d_out_tag.hi, 27'b0};
      s6.pden    <= (d_out_tag.h == '0) ? 32'd1 : d_out_tag.h;
    end
  end

  // dividers: distance gain and both pan ratios
  qtag_t          q_in_tag, q_out_tag;
  logic           q_vld;
  logic [QUO_W-1:0] gq, lq, rq;

  always_comb begin
    q_in_tag.spatial = s6.spatial;
    q_in_tag.base    = s6.base;
    q_in_tag.gsel    = s6.gsel;
    q_in_tag.hzero   = s6.hzero;
  end

  dap_div_pipe #(
    .QW    (QUO_W),
    .DW    (GDEN_W),
    .TAG_W ($bits(qtag_t))
  ) u_g_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s6_vld),
    .in_num    (s6.gnum),
    .in_den    (s6.gden),
    .in_tag    (q_in_tag),
    .out_valid (q_vld),
    .out_quo   (gq),
    .out_tag   (q_out_tag)
  );

  dap_div_pipe #(
    .QW    (QUO_W),
    .DW    (H_W),
    .TAG_W (1)
  ) u_l_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s6_vld),
    .in_num    (s6.lnum),
    .in_den    (s6.pden),
    .in_tag    (1'b0),
    .out_valid (),
    .out_quo   (lq),
    .out_tag   ()
  );

  dap_div_pipe #(
    .QW    (QUO_W),
    .DW    (H_W),
    .TAG_W (1)
  ) u_r_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s6_vld),
    .in_num    (s6.rnum),
    .in_den    (s6.pden),
    .in_tag    (1'b0),
    .out_valid (),
    .out_quo   (rq),
    .out_tag   ()
  );

  // pan factor roots
  ftag_t            f_in_tag, f_out_tag;
  logic [2*FAC_W-1:0] lrad, rrad;
  logic             f_vld;
  logic [FAC_W-1:0] lf, rf;

  always_comb begin
    f_in_tag.spatial = q_out_tag.spatial;
    f_in_tag.base    = q_out_tag.base;
    unique case (q_out_tag.gsel)
      GSEL_ONE:  f_in_tag.g = GAIN_ONE;
      GSEL_ZERO: f_in_tag.g = '0;
      GSEL_DIV:  f_in_tag.g = {1'b0, gq[13:0]};
      default:   f_in_tag.g = '0;
    endcase
    lrad = {1'b0, q_out_tag.hzero ? PAN_CENTER : lq};
    rrad = {1'b0, q_out_tag.hzero ? PAN_CENTER : rq};
  end

  dap_sqrt_pipe #(
    .RW    (FAC_W),
    .TAG_W ($bits(ftag_t))
  ) u_l_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (q_vld),
    .in_rad    (lrad),
    .in_tag    (f_in_tag),
    .out_valid (f_vld),
    .out_root  (lf),
    .out_tag   (f_out_tag)
  );

  dap_sqrt_pipe #(
    .RW    (FAC_W),
    .TAG_W (1)
  ) u_r_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (q_vld),
    .in_rad    (rrad),
    .in_tag    (1'b0),
    .out_valid (),
    .out_root  (rf),
    .out_tag   ()
  );

  // stage 7: base times distance gain
  logic [30:0] bg_c;

  assign bg_c = f_out_tag.base * f_out_tag.g;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_vld <= 1'b0;
    end else if (adv) begin
      s7_vld <= f_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7.spatial <= f_out_tag.spatial;
      s7.base    <= f_out_tag.base;
      s7.bg      <= bg_c;
      s7.lf      <= lf;
      s7.rf      <= rf;
    end
  end

  // output register
  logic [45:0] lprod, rprod;

  always_comb begin
    lprod = s7.bg * s7.lf;
    rprod = s7.bg * s7.rf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s7_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      left_gain  <= s7.spatial ? lprod[43:28] : s7.base;
      right_gain <= s7.spatial ? rprod[43:28] : s7.base;
    end
  end

endmodule

// File: rtl/dap_sqrt_pipe.sv
module dap_sqrt_pipe #(
  parameter int RW    = 16,
  parameter int TAG_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2*RW-1:0]   in_rad,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_valid,
  output logic [RW-1:0]     out_root,
  output logic [TAG_W-1:0]  out_tag
);

  logic [2*RW-1:0]  rad  [RW];
  logic [RW+1:0]    rem  [RW];
  logic [RW-1:0]    root [RW];
  logic [TAG_W-1:0] tag  [RW];
  logic             vld  [RW];

  // one root bit per stage, restoring
  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic [2*RW-1:0]  p_rad;
    logic [RW+1:0]    p_rem;
    logic [RW-1:0]    p_root;
    logic [TAG_W-1:0] p_tag;
    logic             p_vld;
    logic [RW+1:0]    sh;
    logic [RW+1:0]    trial;
    logic             ge;

    if (i == 0) begin : g_first
      assign p_rad  = in_rad;
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_tag  = in_tag;
      assign p_vld  = in_valid;
    end else begin : g_next
      assign p_rad  = rad[i-1];
      assign p_rem  = rem[i-1];
      assign p_root = root[i-1];
      assign p_tag  = tag[i-1];
      assign p_vld  = vld[i-1];
    end

    always_comb begin
      sh    = {p_rem[RW-1:0], p_rad[2*RW-1 -: 2]};
      trial = {p_root, 2'b01};
      ge    = (sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[i]  <= {p_rad[2*RW-3:0], 2'b00};
        rem[i]  <= ge ? (sh - trial) : sh;
        root[i] <= {p_root[RW-2:0], ge};
        tag[i]  <= p_tag;
      end
    end
  end

  assign out_valid = vld[RW-1];
  assign out_root  = root[RW-1];
  assign out_tag   = tag[RW-1];

endmodule

// File: rtl/dap_div_pipe.sv
module dap_div_pipe #(
  parameter int QW    = 8,
  parameter int DW    = 8,
  parameter int TAG_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [QW+DW-1:0]  in_num,
  input  logic [DW-1:0]     in_den,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_valid,
  output logic [QW-1:0]     out_quo,
  output logic [TAG_W-1:0]  out_tag
);

  logic [DW-1:0]    rem [QW];
  logic [QW-1:0]    low [QW];
  logic [QW-1:0]    quo [QW];
  logic [DW-1:0]    den [QW];
  logic [TAG_W-1:0] tag [QW];
  logic             vld [QW];

  // one quotient bit per stage; upper numerator part is below the divisor
  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW-1:0]    p_rem;
    logic [QW-1:0]    p_low;
    logic [QW-1:0]    p_quo;
    logic [DW-1:0]    p_den;
    logic [TAG_W-1:0] p_tag;
    logic             p_vld;
    logic [DW:0]      sh;
    logic [DW:0]      dif;
    logic             ge;

    if (i == 0) begin : g_first
      assign p_rem = in_num[QW+DW-1:QW];
      assign p_low = in_num[QW-1:0];
      assign p_quo = '0;
      assign p_den = in_den;
      assign p_tag = in_tag;
      assign p_vld = in_valid;
    end else begin : g_next
      assign p_rem = rem[i-1];
      assign p_low = low[i-1];
      assign p_quo = quo[i-1];
      assign p_den = den[i-1];
      assign p_tag = tag[i-1];
      assign p_vld = vld[i-1];
    end

    always_comb begin
      sh  = {p_rem, p_low[QW-1]};
      ge  = (sh >= {1'b0, p_den});
      dif = sh - {1'b0, p_den};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= ge ? dif[DW-1:0] : sh[DW-1:0];
        low[i] <= {p_low[QW-2:0], 1'b0};
        quo[i] <= {p_quo[QW-2:0], ge};
        den[i] <= p_den;
        tag[i] <= p_tag;
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign out_quo   = quo[QW-1];
  assign out_tag   = tag[QW-1];

endmodule
